// File: src/sgva_pkg.sv
// Shared types and constants for the softened gravity velocity accumulator.
// Used by the top level; depends on nothing.
package sgva_pkg;

	// Gravitational constant scaled by 2^64, rounded
	localparam logic [63:0] GQ64 = 64'd1231191040;

	localparam int MAG_W  = 33;
	localparam int ROOT_W = 34;
	localparam int SUM_W  = 68;
	localparam int REM_W  = 40;

	// Per-item sequencer
	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_SQ   = 10'b00_0000_0010,
		ST_ROOT = 10'b00_0000_0100,
		ST_DSQ  = 10'b00_0000_1000,
		ST_MASS = 10'b00_0001_0000,
		ST_ACC  = 10'b00_0010_0000,
		ST_STEP = 10'b00_0100_0000,
		ST_VMUL = 10'b00_1000_0000,
		ST_VDIV = 10'b01_0000_0000,
		ST_DONE = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		REG_MIN_DIST  = 2'd0,
		REG_SKIP_DIST = 2'd1,
		REG_SOFT_SQ   = 2'd2,
		REG_STEPS     = 2'd3
	} cfg_reg_t;

endpackage

// File: src/sgva_mul.sv
// Bit-serial shift-and-add multiplier, 64 x 64 -> 128, one multiplier bit a cycle.
// Finishes early once the remaining multiplier bits are zero. Depends on nothing.
module sgva_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         busy,
	output logic [127:0] prod
);

	logic         busy_q;
	logic [127:0] mcand_q;
	logic [63:0]  mplier_q;
	logic [127:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && mplier_q == 64'd0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {64'd0, a};
			mplier_q <= b;
			prod_q   <= 128'd0;
		end else if (busy_q && mplier_q != 64'd0) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[126:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[63:1]};
		end
	end

	assign busy = busy_q;
	assign prod = prod_q;

endmodule

// File: src/sgva_div.sv
// Restoring divider, one quotient bit a cycle, numerator taken from its top bit down.
// The caller left-aligns the numerator and gives the number of bits to consume.
module sgva_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	input  logic [7:0]   iters,
	output logic         busy,
	output logic [63:0]  quo
);

	logic         busy_q;
	logic [7:0]   cnt_q;
	logic [127:0] num_q;
	logic [63:0]  den_q;
	logic [63:0]  rem_q;
	logic [63:0]  quo_q;
	logic [64:0]  trial;
	logic [64:0]  diff;

	assign trial = {rem_q, num_q[127]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 8'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 8'd1;
			if (cnt_q == 8'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= 64'd0;
			quo_q <= 64'd0;
		end else if (busy_q) begin
			num_q <= {num_q[126:0], 1'b0};
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// File: src/softened_gravity_velocity_accumulator_top.sv
// Softened gravity velocity accumulator: top level with sequencer and velocity state.
// Depends on sgva_pkg, sgva_mul and sgva_div.
//
// One item is worked at a time; in_ready is high only while the sequencer is idle. A collide
// item goes straight to the done state. A pull item runs through one bit-serial multiplier
// (one multiplier bit a cycle, stopping at the last set bit) and one restoring divider (one
// quotient bit a cycle): three squarings, a square root done in the sequencer itself, the
// distance squared, G times mass, two divisions, then per axis a multiply and a division.
// A skipped pull ends after the square root. The result sits in an output register, so the
// next item is taken as soon as the sequencer is idle.
module softened_gravity_velocity_accumulator_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [31:0] body_x,
	input  logic signed [31:0] body_y,
	input  logic signed [31:0] body_z,
	input  logic signed [31:0] self_x,
	input  logic signed [31:0] self_y,
	input  logic signed [31:0] self_z,
	input  logic [47:0]        body_mass,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] vel_z,
	output logic               skipped
);

	localparam int NUM_SHIFT = 64 - 2 * FRAC_BITS;

	sgva_pkg::state_t state_q;
	logic             ph_q;
	logic [1:0]       ax_q;
	logic [5:0]       cnt_q;

	logic [30:0] min_dist_q;
	logic [15:0] skip_dist_q;
	logic [30:0] soft_sq_q;
	logic [9:0]  steps_q;

	logic [sgva_pkg::MAG_W-1:0]  mag_q [3];
	logic [2:0]                  neg_q;
	logic [47:0]                 mass_q;
	logic [sgva_pkg::SUM_W-1:0]  sum_q;
	logic [sgva_pkg::REM_W-1:0]  rem_q;
	logic [sgva_pkg::ROOT_W-1:0] root_q;
	logic [63:0]                 den_q;
	logic [63:0]                 work_q;
	logic signed [31:0]          vel_q [3];
	logic                        skip_q;

	logic               out_valid_q;
	logic signed [31:0] vel_x_q, vel_y_q, vel_z_q;
	logic               skipped_q;

	logic         mul_start, mul_busy;
	logic [63:0]  mul_a, mul_b;
	logic [127:0] mul_prod;
	logic         div_start, div_busy;
	logic [127:0] div_num;
	logic [63:0]  div_den;
	logic [7:0]   div_iters;
	logic [63:0]  div_quo;

	logic                        in_xfer;
	logic                        out_load;
	logic signed [32:0]          diff_x, diff_y, diff_z;
	logic [sgva_pkg::REM_W-1:0]  rem_sh;
	logic [sgva_pkg::REM_W-1:0]  root_trial;
	logic [sgva_pkg::ROOT_W-1:0] d_clamp;
	logic [63:0]                 den_sum;
	logic [63:0]                 steps_ext;
	logic [33:0]                 delta;
	logic signed [35:0]          vel_sum;
	logic signed [31:0]          vel_sat;

	assign in_ready = (state_q == sgva_pkg::ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_load = (state_q == sgva_pkg::ST_DONE) && (!out_valid_q || out_ready);

	assign diff_x = 33'(body_x) - 33'(self_x);
	assign diff_y = 33'(body_y) - 33'(self_y);
	assign diff_z = 33'(body_z) - 33'(self_z);

	assign rem_sh     = {rem_q[sgva_pkg::REM_W-3:0], sum_q[sgva_pkg::SUM_W-1 -: 2]};
	assign root_trial = {4'd0, root_q, 2'b01};
	assign d_clamp    = (root_q > {3'd0, min_dist_q}) ? root_q : {3'd0, min_dist_q};
	assign den_sum    = mul_prod[FRAC_BITS +: 64] + {33'd0, soft_sq_q};
	assign steps_ext  = (steps_q == 10'd0) ? 64'd1 : {54'd0, steps_q};

	assign delta   = (div_quo > 64'h2_0000_0000) ? 34'h2_0000_0000 : div_quo[33:0];
	assign vel_sum = neg_q[ax_q] ? 36'(vel_q[ax_q]) - $signed({2'b00, delta})
	                             : 36'(vel_q[ax_q]) + $signed({2'b00, delta});
	always_comb begin
		if (vel_sum > 36'sd2147483647) begin
			vel_sat = 32'sh7FFF_FFFF;
		end else if (vel_sum < -36'sd2147483648) begin
			vel_sat = 32'sh8000_0000;
		end else begin
			vel_sat = vel_sum[31:0];
		end
	end

	// Operand selection for the shared units
	always_comb begin
		mul_start = 1'b0;
		mul_a     = 64'd0;
		mul_b     = 64'd0;
		div_start = 1'b0;
		div_num   = 128'd0;
		div_den   = 64'd1;
		div_iters = 8'd64;
		case (state_q)
			sgva_pkg::ST_SQ: begin
				mul_start = !ph_q;
				mul_a     = {31'd0, mag_q[ax_q]};
				mul_b     = {31'd0, mag_q[ax_q]};
			end
			sgva_pkg::ST_DSQ: begin
				mul_start = !ph_q;
				mul_a     = {30'd0, d_clamp};
				mul_b     = {30'd0, d_clamp};
			end
			sgva_pkg::ST_MASS: begin
				mul_start = !ph_q;
				mul_a     = sgva_pkg::GQ64;
				mul_b     = {16'd0, mass_q};
			end
			sgva_pkg::ST_ACC: begin
				div_start = !ph_q;
				div_num   = {work_q, 64'd0};
				div_den   = den_q;
			end
			sgva_pkg::ST_STEP: begin
				div_start = !ph_q;
				div_num   = {work_q, 64'd0};
				div_den   = steps_ext;
			end
			sgva_pkg::ST_VMUL: begin
				mul_start = !ph_q;
				mul_a     = work_q;
				mul_b     = {31'd0, mag_q[ax_q]};
			end
			sgva_pkg::ST_VDIV: begin
				div_start = !ph_q;
				div_num   = mul_prod;
				div_den   = {30'd0, root_q};
				div_iters = 8'd128;
			end
			default: begin
			end
		endcase
	end

	sgva_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	sgva_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.iters  (div_iters),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q  <= 31'd327680;
			skip_dist_q <= 16'd7;
			soft_sq_q   <= 31'd65536;
			steps_q     <= 10'd60;
		end else if (cfg_we) begin
			unique case (sgva_pkg::cfg_reg_t'(cfg_index))
				sgva_pkg::REG_MIN_DIST:  min_dist_q  <= cfg_data;
				sgva_pkg::REG_SKIP_DIST: skip_dist_q <= cfg_data[15:0];
				sgva_pkg::REG_SOFT_SQ:   soft_sq_q   <= cfg_data;
				sgva_pkg::REG_STEPS:     steps_q     <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sgva_pkg::ST_IDLE;
			ph_q        <= 1'b0;
			ax_q        <= 2'd0;
			cnt_q       <= 6'd0;
			vel_q[0]    <= 32'sd0;
			vel_q[1]    <= 32'sd0;
			vel_q[2]    <= 32'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sgva_pkg::ST_IDLE: begin
					if (in_xfer) begin
						ph_q <= 1'b0;
						ax_q <= 2'd0;
						if (operation) begin
							vel_q[0] <= 32'sd0;
							vel_q[1] <= 32'sd0;
							vel_q[2] <= 32'sd0;
							state_q  <= sgva_pkg::ST_DONE;
						end else begin
							state_q <= sgva_pkg::ST_SQ;
						end
					end
				end
				sgva_pkg::ST_SQ: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!mul_busy) begin
						ph_q <= 1'b0;
						if (ax_q == 2'd2) begin
							ax_q    <= 2'd0;
							cnt_q   <= 6'd0;
							state_q <= sgva_pkg::ST_ROOT;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end
				end
				sgva_pkg::ST_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(sgva_pkg::ROOT_W - 1)) begin
						state_q <= sgva_pkg::ST_DSQ;
					end
				end
				sgva_pkg::ST_DSQ: begin
					// a distance of zero has no direction: skip it as well
					if (!ph_q && (root_q == '0 || root_q < {18'd0, skip_dist_q})) begin
						state_q <= sgva_pkg::ST_DONE;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!mul_busy) begin
						ph_q    <= 1'b0;
						state_q <= sgva_pkg::ST_MASS;
					end
				end
				sgva_pkg::ST_MASS: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!mul_busy) begin
						ph_q    <= 1'b0;
						state_q <= sgva_pkg::ST_ACC;
					end
				end
				sgva_pkg::ST_ACC: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!div_busy) begin
						ph_q    <= 1'b0;
						state_q <= sgva_pkg::ST_STEP;
					end
				end
				sgva_pkg::ST_STEP: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!div_busy) begin
						ph_q    <= 1'b0;
						state_q <= sgva_pkg::ST_VMUL;
					end
				end
				sgva_pkg::ST_VMUL: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!mul_busy) begin
						ph_q    <= 1'b0;
						state_q <= sgva_pkg::ST_VDIV;
					end
				end
				sgva_pkg::ST_VDIV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (!div_busy) begin
						ph_q        <= 1'b0;
						vel_q[ax_q] <= vel_sat;
						if (ax_q == 2'd2) begin
							state_q <= sgva_pkg::ST_DONE;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= sgva_pkg::ST_VMUL;
						end
					end
				end
				sgva_pkg::ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= sgva_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sgva_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			sgva_pkg::ST_IDLE: begin
				if (in_xfer) begin
					mag_q[0] <= diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
					mag_q[1] <= diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
					mag_q[2] <= diff_z[32] ? 33'(-diff_z) : 33'(diff_z);
					neg_q    <= {diff_z[32], diff_y[32], diff_x[32]};
					mass_q   <= body_mass;
					sum_q    <= '0;
					rem_q    <= '0;
					root_q   <= '0;
					skip_q   <= !operation;
				end
			end
			sgva_pkg::ST_SQ: begin
				if (ph_q && !mul_busy) begin
					sum_q <= sum_q + mul_prod[sgva_pkg::SUM_W-1:0];
				end
			end
			sgva_pkg::ST_ROOT: begin
				// two radicand bits a cycle
				sum_q <= {sum_q[sgva_pkg::SUM_W-3:0], 2'b00};
				if (rem_sh >= root_trial) begin
					rem_q  <= rem_sh - root_trial;
					root_q <= {root_q[sgva_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[sgva_pkg::ROOT_W-2:0], 1'b0};
				end
			end
			sgva_pkg::ST_DSQ: begin
				if (ph_q && !mul_busy) begin
					skip_q <= 1'b0;
					den_q  <= (den_sum == 64'd0) ? 64'd1 : den_sum;
				end
			end
			sgva_pkg::ST_MASS: begin
				if (ph_q && !mul_busy) begin
					work_q <= mul_prod[NUM_SHIFT +: 64];
				end
			end
			sgva_pkg::ST_ACC, sgva_pkg::ST_STEP: begin
				if (ph_q && !div_busy) begin
					work_q <= div_quo;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vel_x_q   <= vel_q[0];
			vel_y_q   <= vel_q[1];
			vel_z_q   <= vel_q[2];
			skipped_q <= skip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign vel_x     = vel_x_q;
	assign vel_y     = vel_y_q;
	assign vel_z     = vel_z_q;
	assign skipped   = skipped_q;

endmodule
